// ===== design/ac3_hdr_pkg.sv =====
// Shared types, status codes and lookup tables for the AC-3 header parser.
`default_nettype none

package ac3_hdr_pkg;

  localparam logic [15:0] SYNC_WORD = 16'h0B77;
  localparam logic [5:0] NUM_SIZE_CODES = 6'd38;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SYNC = 3'd1,
    ST_BAD_RATE = 3'd2,
    ST_BAD_SIZE = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  typedef struct packed {
    logic [23:0] specific_box_bits;
    logic [2:0]  channel_count;
    logic [15:0] sample_rate_hz;
    logic [11:0] frame_bytes;
    logic        lfe_on;
    logic [2:0]  coding_mode;
    logic [2:0]  stream_mode;
    logic [4:0]  stream_id;
    logic [5:0]  size_code;
    logic [1:0]  rate_code;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_word_t;

  function automatic logic [15:0] sample_rate(input logic [1:0] fs);
    logic [15:0] r;
    case (fs)
      2'd0:    r = 16'd48000;
      2'd1:    r = 16'd44100;
      2'd2:    r = 16'd32000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mode_channels(input logic [2:0] acmod);
    logic [2:0] c;
    case (acmod)
      3'd0:    c = 3'd2;
      3'd1:    c = 3'd1;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd3;
      3'd4:    c = 3'd3;
      3'd5:    c = 3'd4;
      3'd6:    c = 3'd4;
      default: c = 3'd5;
    endcase
    return c;
  endfunction

  // Frame size in 16-bit words for a size code and rate code.
  function automatic logic [10:0] frame_words(input logic [5:0] fsz, input logic [1:0] fs);
    logic [32:0] w;
    logic [10:0] r;
    case (fsz)
      6'd0:    w = {11'd64,   11'd69,   11'd96};
      6'd1:    w = {11'd64,   11'd70,   11'd96};
      6'd2:    w = {11'd80,   11'd87,   11'd120};
      6'd3:    w = {11'd80,   11'd88,   11'd120};
      6'd4:    w = {11'd96,   11'd104,  11'd144};
      6'd5:    w = {11'd96,   11'd105,  11'd144};
      6'd6:    w = {11'd112,  11'd121,  11'd168};
      6'd7:    w = {11'd112,  11'd122,  11'd168};
      6'd8:    w = {11'd128,  11'd139,  11'd192};
      6'd9:    w = {11'd128,  11'd140,  11'd192};
      6'd10:   w = {11'd160,  11'd174,  11'd240};
      6'd11:   w = {11'd160,  11'd175,  11'd240};
      6'd12:   w = {11'd192,  11'd208,  11'd288};
      6'd13:   w = {11'd192,  11'd209,  11'd288};
      6'd14:   w = {11'd224,  11'd243,  11'd336};
      6'd15:   w = {11'd224,  11'd244,  11'd336};
      6'd16:   w = {11'd256,  11'd278,  11'd384};
      6'd17:   w = {11'd256,  11'd279,  11'd384};
      6'd18:   w = {11'd320,  11'd348,  11'd480};
      6'd19:   w = {11'd320,  11'd349,  11'd480};
      6'd20:   w = {11'd384,  11'd417,  11'd576};
      6'd21:   w = {11'd384,  11'd418,  11'd576};
      6'd22:   w = {11'd448,  11'd487,  11'd672};
      6'd23:   w = {11'd448,  11'd488,  11'd672};
      6'd24:   w = {11'd512,  11'd557,  11'd768};
      6'd25:   w = {11'd512,  11'd558,  11'd768};
      6'd26:   w = {11'd640,  11'd696,  11'd960};
      6'd27:   w = {11'd640,  11'd697,  11'd960};
      6'd28:   w = {11'd768,  11'd835,  11'd1152};
      6'd29:   w = {11'd768,  11'd836,  11'd1152};
      6'd30:   w = {11'd896,  11'd975,  11'd1344};
      6'd31:   w = {11'd896,  11'd976,  11'd1344};
      6'd32:   w = {11'd1024, 11'd1114, 11'd1536};
      6'd33:   w = {11'd1024, 11'd1115, 11'd1536};
      6'd34:   w = {11'd1152, 11'd1253, 11'd1728};
      6'd35:   w = {11'd1152, 11'd1254, 11'd1728};
      6'd36:   w = {11'd1280, 11'd1393, 11'd1920};
      6'd37:   w = {11'd1280, 11'd1394, 11'd1920};
      default: w = 33'd0;
    endcase
    case (fs)
      2'd0:    r = w[32:22];
      2'd1:    r = w[21:11];
      2'd2:    r = w[10:0];
      default: r = 11'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/ac3_hdr_parse.sv =====
// Byte-by-byte header capture and field decode for one AC-3 frame.
`default_nettype none

module ac3_hdr_parse (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [7:0]                byte_value,
  input  wire logic                      first_byte,
  input  wire logic                      last_byte,
  output ac3_hdr_pkg::result_word_t      result
);

  logic [3:0] count;
  logic       done;
  logic [7:0] hold [7];

  logic       active;
  logic [3:0] base;
  logic [3:0] k;
  logic [7:0] b [8];
  logic       hit;
  logic [1:0] extra;
  logic [1:0] fs;
  logic [5:0] fsz;
  logic       lfe;
  ac3_hdr_pkg::result_t res;

  always_comb begin
    active = first_byte | ~done;
    base   = first_byte ? 4'd0 : count;
    k      = base + 4'd1;
    for (int i = 0; i < 7; i++) begin
      b[i] = (base == 4'(i)) ? byte_value : hold[i];
    end
    b[7] = byte_value;

    fs    = b[4][7:6];
    fsz   = b[4][5:0];
    extra = 2'(((b[6][5] && (b[6][7:5] != 3'd1)) ? 1 : 0) + (b[6][7] ? 1 : 0)
                + ((b[6][7:5] == 3'd2) ? 1 : 0));
    case (extra)
      2'd0:    lfe = b[6][4];
      2'd1:    lfe = b[6][2];
      2'd2:    lfe = b[6][0];
      default: lfe = b[7][6];
    endcase

    res = '0;
    hit = 1'b0;
    if (k >= 4'd2 && {b[0], b[1]} != ac3_hdr_pkg::SYNC_WORD) begin
      hit        = 1'b1;
      res.status = ac3_hdr_pkg::ST_BAD_SYNC;
    end else if (k >= 4'd5) begin
      if (fs == 2'd3) begin
        hit           = 1'b1;
        res.status    = ac3_hdr_pkg::ST_BAD_RATE;
        res.rate_code = fs;
        res.size_code = fsz;
      end else if (fsz >= ac3_hdr_pkg::NUM_SIZE_CODES) begin
        hit           = 1'b1;
        res.status    = ac3_hdr_pkg::ST_BAD_SIZE;
        res.rate_code = fs;
        res.size_code = fsz;
      end else if (k == 4'd8 || (k == 4'd7 && extra != 2'd3)) begin
        hit                   = 1'b1;
        res.status            = ac3_hdr_pkg::ST_OK;
        res.rate_code         = fs;
        res.size_code         = fsz;
        res.stream_id         = b[5][7:3];
        res.stream_mode       = b[5][2:0];
        res.coding_mode       = b[6][7:5];
        res.lfe_on            = lfe;
        res.frame_bytes       = {ac3_hdr_pkg::frame_words(fsz, fs), 1'b0};
        res.sample_rate_hz    = ac3_hdr_pkg::sample_rate(fs);
        res.channel_count     = ac3_hdr_pkg::mode_channels(b[6][7:5]) + {2'd0, lfe};
        res.specific_box_bits = {fs, b[5][7:3], b[5][2:0], b[6][7:5], lfe, fsz[5:1], 5'd0};
      end
    end
    if (!hit && last_byte) begin
      hit        = 1'b1;
      res.status = ac3_hdr_pkg::ST_TRUNC;
    end

    result.valid = accept & active & hit;
    result.data  = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 4'd0;
      done  <= 1'b1;
    end else if (accept && active) begin
      count <= k;
      done  <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active && base < 4'd7) begin
      hold[base[2:0]] <= byte_value;
    end
  end

endmodule

`default_nettype wire

// ===== design/ac3_hdr_out.sv =====
// Two-entry result buffer; byte input flows while the receiver stalls until it is full.
`default_nettype none

module ac3_hdr_out (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ac3_hdr_pkg::result_word_t push,
  output logic                           space,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output ac3_hdr_pkg::result_t           out_data
);

  logic [1:0]           count;
  ac3_hdr_pkg::result_t head;
  ac3_hdr_pkg::result_t tail;
  logic                 pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = head;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push.valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push.valid) head <= push.data;
      end
      2'd1: begin
        if (push.valid && pop) head <= push.data;
        else if (push.valid) tail <= push.data;
      end
      2'd2: begin
        if (pop) head <= tail;
      end
      default: begin
        head <= head;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ac3_sync_header_parser.sv =====
// Top level of the AC-3 sync info and bitstream header parser.
// Frame bytes arrive on the s_ channel, one byte per word: s_tuser marks the
// first byte of a frame buffer and s_tlast its final byte. The block reads the
// sync word, CRC, rate and size codes, stream id and mode, coding mode, skips
// the mix-level bits and takes the LFE flag. One result word leaves on the m_
// channel as soon as the header is complete, on a bad sync word or code, or
// when the buffer ends early; later bytes are dropped until the next first byte.
// A byte is taken every cycle while s_tready is high; the result word is registered
// in the result buffer and shown on m_tvalid once any earlier result has left.
// A two-entry result buffer keeps s_tready high while one result waits, so the
// input stalls only while two results are held.
// Reset empties the result buffer and waits for a first byte.
`default_nettype none

module ac3_sync_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // byte_value
  input  wire logic        s_tuser,   // first_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata    // status, rate_code, size_code, stream_id,
                                      // stream_mode, coding_mode, lfe_on, frame_bytes,
                                      // sample_rate_hz, channel_count,
                                      // specific_box_bits, zero pad
);

  logic                      accept;
  ac3_hdr_pkg::result_word_t result;
  ac3_hdr_pkg::result_t      out_data;

  assign accept = s_tvalid & s_tready;

  ac3_hdr_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (s_tdata),
    .first_byte (s_tuser),
    .last_byte  (s_tlast),
    .result     (result)
  );

  ac3_hdr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (result),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {2'b00, out_data};

  a_full_holds_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid) else $error("buffer full with no output word");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("output valid right after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= 3'(ac3_hdr_pkg::ST_TRUNC)))
    else $error("status code out of range");

  a_ok_has_size: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] == 3'(ac3_hdr_pkg::ST_OK)) |->
    (m_tdata[34:23] != 12'd0 && m_tdata[50:35] != 16'd0))
    else $error("good header without frame size or rate");

endmodule

`default_nettype wire
